// ----- rtl/serial_keyboard_receiver_unit_macros.svh -----
// assertion macros for the keyboard serial receiver
`ifndef SERIAL_KEYBOARD_RECEIVER_UNIT_MACROS_SVH
`define SERIAL_KEYBOARD_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTH
// condition holds in the same cycle
`define SKR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skr assertion failed");
// condition holds in the next cycle
`define SKR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skr assertion failed");
`else
`define SKR_ASSERT_NOW(label, ante, cons)
`define SKR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/skr_pkg.sv -----
`timescale 1ns / 1ps
package skr_pkg;

  localparam int COUNTER_BITS = 10;
  localparam int HS_W         = 10;
  localparam int CMP_W        = (COUNTER_BITS + 1 > HS_W) ? COUNTER_BITS + 1 : HS_W;
  localparam logic [CMP_W-1:0] COUNTER_MAX = CMP_W'((1 << COUNTER_BITS) - 1);

  localparam logic [HS_W-1:0] HS_TICKS_RESET = HS_W'(100);

  localparam logic [6:0] CODE_CAPS     = 7'h62;
  localparam logic [6:0] CODE_LAST_KEY = 7'h67;
  localparam logic [7:0] CODE_RST_WARN = 8'h78;
  localparam logic [7:0] CODE_SPC_FIRST = 8'hf9;

  typedef enum logic [2:0] {
    PH_SYNC_LO_WAIT = 3'd0,
    PH_SYNC_HI_WAIT = 3'd1,
    PH_HANDSHAKE    = 3'd2,
    PH_READ         = 3'd3,
    PH_BIT_WAIT     = 3'd4,
    PH_RESET_WAIT   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_KEY     = 2'd1,
    KIND_CAPS    = 2'd2,
    KIND_SPECIAL = 2'd3
  } event_kind_t;

  localparam logic [3:0] SPK_UNKNOWN  = 4'd0;
  localparam logic [3:0] SPK_RST_WARN = 4'd1;
  localparam logic [3:0] SPK_FIRST    = 4'd2;

  function automatic logic [3:0] classify_special(input logic [7:0] b);
    logic [7:0] ofs;
    ofs = b - CODE_SPC_FIRST;
    if (b == CODE_RST_WARN) begin
      return SPK_RST_WARN;
    end else if (b >= CODE_SPC_FIRST) begin
      return ofs[3:0] + SPK_FIRST;
    end else begin
      return SPK_UNKNOWN;
    end
  endfunction

endpackage

// ----- rtl/skr_ifs.sv -----
`timescale 1ns / 1ps
interface skr_in_if;
  logic valid;
  logic ready;
  logic clock_level;
  logic data_level;
  logic reset_level;

  modport source (output valid, output clock_level, output data_level,
                  output reset_level, input ready);
  modport sink (input valid, input clock_level, input data_level,
                input reset_level, output ready);
endinterface

interface skr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] event_code;
  logic       key_down;
  logic [3:0] special_kind;
  logic       caps_led;
  logic       drive_data_low;

  modport source (output valid, output event_kind, output event_code, output key_down,
                  output special_kind, output caps_led, output drive_data_low,
                  input ready);
  modport sink (input valid, input event_kind, input event_code, input key_down,
                input special_kind, input caps_led, input drive_data_low,
                output ready);
endinterface

// ----- rtl/serial_keyboard_receiver_unit.sv -----
// Host side of a keyboard serial link. Each request on in_ch is one pin
// sample tick (clock, data, reset levels; data is active low). Every request
// yields exactly one result on out_ch: event kind, code, up/down flag, special
// byte class, the caps lock LED and the data-low handshake drive.
// cfg_we/cfg_wdata load the handshake pulse length in ticks; write it only
// while no result is pending.
// A sample accepted at one edge has its result on out_ch after that
// edge. Throughput: one sample per cycle, set by the single result
// register; in_ch stays ready while the result register is empty or being
// taken in the same cycle.
// If out_ch stalls, the pending result holds and in_ch drops ready until it
// is taken; no sample is dropped or processed twice.
// Reset (rst_n low, synchronous) returns to the sync wait, clears the caps
// LED and the handshake drive, and loads a pulse length of 100 ticks.
// A low keyboard reset pin forces the reset wait, releases the data drive and
// clears the pulse timer; the caps state is kept.
`timescale 1ns / 1ps
`include "serial_keyboard_receiver_unit_macros.svh"
module serial_keyboard_receiver_unit
  import skr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  skr_in_if.sink            in_ch,
  skr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [HS_W-1:0]   cfg_wdata
);

  logic [HS_W-1:0]         hs_ticks_r;
  phase_t                  phase_r, phase_nxt;
  logic [2:0]              bits_left_r, bits_left_nxt;
  logic [6:0]              shift_code_r, shift_code_nxt;
  logic [COUNTER_BITS-1:0] pulse_count_r, pulse_count_nxt;
  logic                    pulse_active_r, pulse_active_nxt;
  logic                    caps_r, caps_nxt;

  logic                    out_valid_r;
  event_kind_t             kind_r, kind_nxt;
  logic [7:0]              code_r, code_nxt;
  logic                    down_r, down_nxt;
  logic [3:0]              skind_r, skind_nxt;

  logic                    accept;
  logic                    bit_val;
  logic [2:0]              bl_dec;
  logic [CMP_W-1:0]        elapsed;
  logic [7:0]              spc_byte;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign bit_val  = !in_ch.data_level;
  assign bl_dec   = bits_left_r - 3'd1;
  assign elapsed  = CMP_W'(pulse_count_r) + CMP_W'(1);
  assign spc_byte = {bit_val, shift_code_r};

  always_comb begin
    phase_nxt        = phase_r;
    bits_left_nxt    = bits_left_r;
    shift_code_nxt   = shift_code_r;
    pulse_count_nxt  = pulse_count_r;
    pulse_active_nxt = pulse_active_r;
    caps_nxt         = caps_r;
    kind_nxt         = KIND_NONE;
    code_nxt         = 8'd0;
    down_nxt         = 1'b0;
    skind_nxt        = SPK_UNKNOWN;

    if (!in_ch.reset_level && phase_r != PH_RESET_WAIT) begin
      phase_nxt        = PH_RESET_WAIT;
      pulse_active_nxt = 1'b0;
      pulse_count_nxt  = '0;
    end else begin
      case (phase_r)
        PH_RESET_WAIT: begin
          if (in_ch.reset_level) phase_nxt = PH_SYNC_LO_WAIT;
        end
        PH_SYNC_HI_WAIT: begin
          if (in_ch.clock_level) phase_nxt = PH_HANDSHAKE;
        end
        PH_HANDSHAKE: begin
          if (!pulse_active_r) begin
            pulse_active_nxt = 1'b1;
            pulse_count_nxt  = '0;
          end else if (elapsed > CMP_W'(hs_ticks_r) || elapsed > COUNTER_MAX) begin
            pulse_active_nxt = 1'b0;
            pulse_count_nxt  = '0;
            phase_nxt        = PH_BIT_WAIT;
            shift_code_nxt   = 7'd0;
            bits_left_nxt    = 3'd7;
          end else begin
            pulse_count_nxt = elapsed[COUNTER_BITS-1:0];
          end
        end
        PH_BIT_WAIT: begin
          if (!in_ch.clock_level) phase_nxt = PH_READ;
        end
        PH_READ: begin
          if (in_ch.clock_level) begin
            if (bits_left_r != 3'd0) begin
              // bits arrive msb first, index is the decremented count
              bits_left_nxt          = bl_dec;
              shift_code_nxt[bl_dec] = shift_code_r[bl_dec] | bit_val;
              phase_nxt              = PH_BIT_WAIT;
            end else begin
              if (shift_code_r == CODE_CAPS) begin
                kind_nxt = KIND_CAPS;
                code_nxt = {1'b0, shift_code_r};
                down_nxt = !bit_val;
                caps_nxt = !bit_val;
              end else if (shift_code_r <= CODE_LAST_KEY) begin
                kind_nxt = KIND_KEY;
                code_nxt = {1'b0, shift_code_r};
                down_nxt = !bit_val;
              end else begin
                kind_nxt  = KIND_SPECIAL;
                code_nxt  = spc_byte;
                skind_nxt = classify_special(spc_byte);
              end
              phase_nxt = PH_HANDSHAKE;
            end
          end
        end
        default: begin
          // first sync phase and unused codes
          if (!in_ch.clock_level) phase_nxt = PH_SYNC_HI_WAIT;
          else phase_nxt = PH_SYNC_LO_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_ticks_r     <= HS_TICKS_RESET;
      phase_r        <= PH_SYNC_LO_WAIT;
      bits_left_r    <= 3'd7;
      shift_code_r   <= 7'd0;
      pulse_count_r  <= '0;
      pulse_active_r <= 1'b0;
      caps_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) hs_ticks_r <= cfg_wdata;
      if (accept) begin
        phase_r        <= phase_nxt;
        bits_left_r    <= bits_left_nxt;
        shift_code_r   <= shift_code_nxt;
        pulse_count_r  <= pulse_count_nxt;
        pulse_active_r <= pulse_active_nxt;
        caps_r         <= caps_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind_nxt;
      code_r  <= code_nxt;
      down_r  <= down_nxt;
      skind_r <= skind_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_kind     = kind_r;
  assign out_ch.event_code     = code_r;
  assign out_ch.key_down       = down_r;
  assign out_ch.special_kind   = skind_r;
  assign out_ch.caps_led       = caps_r;
  assign out_ch.drive_data_low = pulse_active_r;

  `SKR_ASSERT_NOW(a_drive_only_in_handshake, pulse_active_r, phase_r == PH_HANDSHAKE)
  `SKR_ASSERT_NOW(a_count_needs_drive, pulse_count_r != '0, pulse_active_r)
  `SKR_ASSERT_NEXT(a_pin_reset_waits, accept && !in_ch.reset_level,
                   phase_r == PH_RESET_WAIT && !pulse_active_r)
  `SKR_ASSERT_NOW(a_event_then_handshake, out_valid_r && kind_r != KIND_NONE,
                  phase_r == PH_HANDSHAKE && !pulse_active_r)

endmodule

// ----- bench/serial_keyboard_receiver_unit_test.sv -----
`timescale 1ns / 1ps
module serial_keyboard_receiver_unit_test;
  import skr_pkg::*;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  code;
    logic        key_down;
    logic [3:0]  special;
    logic        caps_led;
    logic        drive_low;
  } key_event_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_TICKS = 120;
  localparam int RANDOM_PHASES = 4;
  localparam int PULSE_MAX = (1 << COUNTER_BITS) - 1;
  localparam logic [HS_W-1:0] HS_AT_RESET = HS_W'(100);
  localparam logic [HS_W-1:0] HS_SHORTEST = '0;
  localparam logic [HS_W-1:0] HS_NOMINAL_MIN = HS_W'(85);

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [HS_W-1:0] cfg_wdata;

  skr_in_if in_ch();
  skr_out_if out_ch();

  serial_keyboard_receiver_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // link state as the block should hold it
  phase_t link_phase;
  logic [2:0] bits_pending;
  logic [6:0] code_shift;
  logic [COUNTER_BITS-1:0] pulse_ticks;
  logic pulse_on;
  logic caps_on;
  logic [HS_W-1:0] hs_limit;

  key_event_t pending_events[$];
  int error_count = 0;
  int tick_count = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int stall_count = 0;
  int seen_keys = 0;
  int seen_caps = 0;
  int seen_special = 0;
  int checked = 0;

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic advance_link(input logic c, input logic d, input logic r,
                              output key_event_t ev);
    logic [COUNTER_BITS:0] elapsed;
    logic bit_val;
    logic [7:0] full;
    ev = '0;
    ev.kind = KIND_NONE;
    bit_val = ~d;
    if (!r && link_phase != PH_RESET_WAIT) begin
      link_phase = PH_RESET_WAIT;
      pulse_on = 1'b0;
      pulse_ticks = '0;
    end else begin
      case (link_phase)
        PH_RESET_WAIT: if (r) link_phase = PH_SYNC_LO_WAIT;
        PH_SYNC_HI_WAIT: if (c) link_phase = PH_HANDSHAKE;
        PH_HANDSHAKE: begin
          if (!pulse_on) begin
            pulse_on = 1'b1;
            pulse_ticks = '0;
          end else begin
            elapsed = {1'b0, pulse_ticks} + 1'b1;
            if (elapsed > hs_limit || elapsed > PULSE_MAX) begin
              pulse_on = 1'b0;
              pulse_ticks = '0;
              link_phase = PH_BIT_WAIT;
              code_shift = '0;
              bits_pending = 3'd7;
            end else begin
              pulse_ticks = elapsed[COUNTER_BITS-1:0];
            end
          end
        end
        PH_BIT_WAIT: if (!c) link_phase = PH_READ;
        PH_READ: begin
          if (c) begin
            if (bits_pending != 0) begin
              bits_pending = bits_pending - 1'b1;
              code_shift = code_shift | (7'(bit_val) << bits_pending);
              link_phase = PH_BIT_WAIT;
            end else begin
              if (code_shift == CODE_CAPS) begin
                ev.kind = KIND_CAPS;
                ev.code = {1'b0, code_shift};
                ev.key_down = ~bit_val;
                caps_on = ~bit_val;
              end else if (code_shift <= CODE_LAST_KEY) begin
                ev.kind = KIND_KEY;
                ev.code = {1'b0, code_shift};
                ev.key_down = ~bit_val;
              end else begin
                full = {bit_val, code_shift};
                ev.kind = KIND_SPECIAL;
                ev.code = full;
                if (full == CODE_RST_WARN) ev.special = SPK_RST_WARN;
                else if (full >= CODE_SPC_FIRST)
                  ev.special = SPK_FIRST + 4'(full - CODE_SPC_FIRST);
                else ev.special = SPK_UNKNOWN;
              end
              link_phase = PH_HANDSHAKE;
            end
          end
        end
        default: link_phase = c ? PH_SYNC_LO_WAIT : PH_SYNC_HI_WAIT;
      endcase
    end
    ev.caps_led = caps_on;
    ev.drive_low = pulse_on;
  endtask

  // one pin sample request, with bursts and gaps on the sending side
  task automatic send_tick(input logic c, input logic d, input logic r);
    key_event_t ev;
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.clock_level <= c;
    in_ch.data_level <= d;
    in_ch.reset_level <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_link(c, d, r, ev);
    pending_events.push_back(ev);
    tick_count++;
  endtask

  task automatic drain_link();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_handshake(input logic [HS_W-1:0] ticks);
    drain_link();
    cfg_we <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    hs_limit = ticks;
  endtask

  // walk the link to the first bit of a fresh frame
  task automatic reach_frame_start();
    while (!(link_phase == PH_BIT_WAIT && bits_pending == 3'd7 && code_shift == '0)) begin
      case (link_phase)
        PH_RESET_WAIT: send_tick(coin(), coin(), 1'b1);
        PH_SYNC_HI_WAIT: send_tick(1'b1, coin(), 1'b1);
        PH_HANDSHAKE: send_tick(coin(), coin(), 1'b1);
        PH_BIT_WAIT: send_tick(1'b0, coin(), 1'b1);
        PH_READ: send_tick(1'b1, coin(), 1'b1);
        default: send_tick(1'b0, coin(), 1'b1);
      endcase
    end
  endtask

  // bits 6..0 then the up/down bit, data active low
  task automatic send_frame(input logic [7:0] b);
    logic bit_val;
    reach_frame_start();
    for (int i = 0; i < 8; i++) begin
      bit_val = (i < 7) ? b[6-i] : b[7];
      repeat ($urandom_range(1, 2)) send_tick(1'b0, coin(), 1'b1);
      send_tick(1'b1, ~bit_val, 1'b1);
      if ($urandom_range(0, 4) == 0) send_tick(1'b1, coin(), 1'b1);
    end
  endtask

  task automatic pin_reset(input int ticks);
    repeat (ticks) send_tick(coin(), coin(), 1'b0);
  endtask

  function automatic logic [7:0] pick_code();
    int sel;
    sel = $urandom_range(0, 7);
    case ($urandom_range(0, 3))
      0: return {coin(), CODE_CAPS};
      1: return (sel == 0) ? CODE_RST_WARN : CODE_SPC_FIRST + 8'(sel - 1);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_default_pulse();
    send_frame(8'h23);
  endtask

  task automatic test_key_events();
    load_handshake(HS_SHORTEST);
    send_frame(8'h00);
    send_frame(8'he7);
    send_frame(8'h5a);
  endtask

  task automatic test_caps_lock();
    send_frame({1'b0, CODE_CAPS});
    send_frame(8'h13);
    send_frame({1'b1, CODE_CAPS});
  endtask

  task automatic test_special_bytes();
    send_frame(CODE_RST_WARN);
    send_frame(8'h68);
    send_frame(8'hf8);
    for (int k = 0; k < 7; k++) send_frame(CODE_SPC_FIRST + 8'(k));
  endtask

  task automatic test_link_reset();
    send_frame({1'b0, CODE_CAPS});
    // cut a frame after two bits
    reach_frame_start();
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    pin_reset(3);
    send_frame(8'h45);
    // pin reset once the handshake pulse is over, before the next frame's first bit
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    pin_reset(2);
    send_frame(8'hc5);
  endtask

  task automatic test_pulse_lengths();
    load_handshake(HS_NOMINAL_MIN);
    send_frame(8'h91);
    load_handshake(HS_W'(1));
    send_frame(8'h2c);
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_handshake(HS_W'($urandom_range(0, 12)));
      start = tick_count;
      while (tick_count - start < RANDOM_TICKS / RANDOM_PHASES) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          send_frame(pick_code());
        end else if (pick < 87) begin
          repeat ($urandom_range(1, 6)) send_tick(coin(), coin(), 1'b1);
        end else if (pick < 94) begin
          pin_reset($urandom_range(1, 4));
        end else begin
          repeat ($urandom_range(1, 8)) send_tick(coin(), coin(), coin());
        end
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // result checker with its own stall pattern
  always @(posedge clk) begin
    key_event_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_events.size() == 0) begin
          flag_mismatch("result with no request pending", 1, 0);
        end else begin
          want = pending_events.pop_front();
          checked++;
          if (out_ch.event_kind != want.kind)
            flag_mismatch("event_kind", out_ch.event_kind, want.kind);
          if (out_ch.event_code != want.code)
            flag_mismatch("event_code", out_ch.event_code, want.code);
          if (out_ch.key_down != want.key_down)
            flag_mismatch("key_down", out_ch.key_down, want.key_down);
          if (out_ch.special_kind != want.special)
            flag_mismatch("special_kind", out_ch.special_kind, want.special);
          if (out_ch.caps_led != want.caps_led)
            flag_mismatch("caps_led", out_ch.caps_led, want.caps_led);
          if (out_ch.drive_data_low != want.drive_low)
            flag_mismatch("drive_data_low", out_ch.drive_data_low, want.drive_low);
          case (want.kind)
            KIND_KEY: seen_keys++;
            KIND_CAPS: seen_caps++;
            KIND_SPECIAL: seen_special++;
            default: ;
          endcase
        end
      end
      stall_count++;
      case (stall_count / 256 % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= (stall_count % 16 < 11);
        default: out_ch.ready <= coin();
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests sent", cycle_count, tick_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.clock_level <= 1'b1;
    in_ch.data_level <= 1'b1;
    in_ch.reset_level <= 1'b1;
    link_phase = PH_SYNC_LO_WAIT;
    bits_pending = 3'd7;
    code_shift = '0;
    pulse_ticks = '0;
    pulse_on = 1'b0;
    caps_on = 1'b0;
    hs_limit = HS_AT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_pulse();
    test_key_events();
    test_caps_lock();
    test_special_bytes();
    test_link_reset();
    test_pulse_lengths();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    for (int w = 0; w < 5000 && pending_events.size() != 0; w++) @(posedge clk);
    if (pending_events.size() != 0)
      flag_mismatch("results never delivered", 0, pending_events.size());
    repeat (5) @(posedge clk);

    $display("%0d pin samples checked; frames seen: %0d key, %0d caps lock, %0d special",
             checked, seen_keys, seen_caps, seen_special);
    $display("handshake lengths from 0 to 100 ticks, link resets, mid-frame aborts");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/skr_pkg.sv
rtl/skr_ifs.sv
rtl/serial_keyboard_receiver_unit.sv
bench/serial_keyboard_receiver_unit_test.sv
